// ===== design/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants for the ray/segment intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TOL_W     = 16;
   localparam int CROSS_W   = 67;

   localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

   localparam logic [1:0] HIT_NONE  = 2'd0;
   localparam logic [1:0] HIT_TOUCH = 2'd1;
   localparam logic [1:0] HIT_CROSS = 2'd2;

   typedef struct packed {
      logic signed [31:0] ray_origin_x;
      logic signed [31:0] ray_origin_y;
      logic signed [31:0] ray_dir_x;
      logic signed [31:0] ray_dir_y;
      logic signed [31:0] seg_start_x;
      logic signed [31:0] seg_start_y;
      logic signed [31:0] seg_vec_x;
      logic signed [31:0] seg_vec_y;
   } req_type;

   typedef struct packed {
      logic [1:0]         hit_kind;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
   } geo_type;

   typedef struct packed {
      logic signed [CROSS_W-1:0] den;
      logic signed [CROSS_W-1:0] nt;
      logic signed [CROSS_W-1:0] ns;
      logic                      touch;
      geo_type                   geo;
   } xs_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
   } side_type;

   typedef struct packed {
      side_type             side;
      logic [CROSS_W-1:0]   rem;
      logic [CROSS_W-1:0]   den;
   } dv_type;

endpackage

// ===== design/ray_segment_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_segment_intersect
// 2D ray against segment intersection in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one query per beat (ray origin, direction, segment start, edge).
//   rsp_*  : one result per query, in order: hit kind and point.
//   csr_*  : tolerance register, written whenever csr_wr_en is high; write
//            it only while no query is in flight.
// Pipeline: FRAC_BITS + 11 register stages (cross, classify, divider, point
//   and the output register); the divider stage count, one quotient bit per
//   stage, makes up most of them.
// Throughput: one query per cycle; every stage is registered and a new
//   request enters each cycle while req_ready is high.
// Reset: clears all valid bits and sets the tolerance to 1.
// Stall: when rsp_ready is low a skid register catches the beat already in
//   flight; the whole pipeline then holds and req_ready drops until the
//   skid register drains. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module ray_segment_intersect #(
   parameter int FRAC_BITS = rsi_pkg::FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rsi_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsi_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [rsi_pkg::TOL_W-1:0] csr_wr_data
);

   logic [rsi_pkg::TOL_W-1:0] tol_ff;
   logic                      en;

   logic                      xs_valid;
   rsi_pkg::xs_type           xs_data;
   logic                      dv_valid;
   rsi_pkg::dv_type           dv_data;
   logic                      q_valid;
   rsi_pkg::side_type         q_side;
   logic [FRAC_BITS:0]        q_val;
   logic                      pt_valid;
   rsi_pkg::rsp_type          pt_data;

   logic                      out_v_ff, skid_v_ff;
   rsi_pkg::rsp_type          out_d_ff, skid_d_ff;
   logic                      pop;

   assign en        = !skid_v_ff;
   assign req_ready = en;
   assign pop       = out_v_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= rsi_pkg::TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   rsi_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .tol       (tol_ff),
      .out_valid (xs_valid),
      .out_data  (xs_data)
   );

   rsi_classify #(.FRAC_BITS(FRAC_BITS)) u_classify (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (xs_valid),
      .in_data   (xs_data),
      .tol       (tol_ff),
      .out_valid (dv_valid),
      .out_data  (dv_data)
   );

   rsi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid),
      .in_data   (dv_data),
      .out_valid (q_valid),
      .out_side  (q_side),
      .out_q     (q_val)
   );

   rsi_point #(.FRAC_BITS(FRAC_BITS)) u_point (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (q_valid),
      .in_side   (q_side),
      .in_q      (q_val),
      .out_valid (pt_valid),
      .out_data  (pt_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            out_d_ff  <= skid_d_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (!out_v_ff || pop) begin
         out_v_ff <= pt_valid;
         out_d_ff <= pt_data;
      end else if (pt_valid) begin
         skid_v_ff <= 1'b1;
         skid_d_ff <= pt_data;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_d_ff;

endmodule

// ===== design/rsi_cross.sv =====
// ----------------------------------------------------------------------------
// rsi_cross
// Offsets, exact cross products and endpoint proximity, three stages.
// ----------------------------------------------------------------------------
module rsi_cross (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  rsi_pkg::req_type      in_data,
   input  logic [rsi_pkg::TOL_W-1:0] tol,
   output logic                  out_valid,
   output rsi_pkg::xs_type       out_data
);

   function automatic logic close_zero(input logic signed [33:0] a,
                                       input logic [rsi_pkg::TOL_W-1:0] t);
      logic [33:0] m;
      m = a[33] ? 34'(-a) : 34'(a);
      return m <= 34'(t);
   endfunction

   logic                  s1_v_ff;
   rsi_pkg::req_type      s1_d_ff;
   logic signed [32:0]    s1_delx_ff, s1_dely_ff, s1_delx_in, s1_dely_in;
   logic signed [33:0]    s1_ex_ff, s1_ey_ff, s1_ex_in, s1_ey_in;

   logic                  s2_v_ff;
   rsi_pkg::geo_type      s2_geo_ff, s2_geo_in;
   logic                  s2_touch_ff, s2_touch_in;
   logic signed [64:0]    s2_dv1_ff, s2_dv2_ff, s2_nt1_ff, s2_nt2_ff, s2_ns1_ff, s2_ns2_ff;
   logic signed [64:0]    s2_dv1_in, s2_dv2_in, s2_nt1_in, s2_nt2_in, s2_ns1_in, s2_ns2_in;

   logic                  s3_v_ff;
   rsi_pkg::xs_type       s3_d_ff, s3_d_in;

   always_comb begin
      s1_delx_in = 33'(in_data.seg_start_x) - 33'(in_data.ray_origin_x);
      s1_dely_in = 33'(in_data.seg_start_y) - 33'(in_data.ray_origin_y);
      s1_ex_in   = 34'(in_data.seg_start_x) + 34'(in_data.seg_vec_x)
                 - 34'(in_data.ray_origin_x);
      s1_ey_in   = 34'(in_data.seg_start_y) + 34'(in_data.seg_vec_y)
                 - 34'(in_data.ray_origin_y);
   end

   always_comb begin
      s2_dv1_in = s1_d_ff.ray_dir_x * s1_d_ff.seg_vec_y;
      s2_dv2_in = s1_d_ff.seg_vec_x * s1_d_ff.ray_dir_y;
      s2_nt1_in = s1_delx_ff * s1_d_ff.ray_dir_y;
      s2_nt2_in = s1_d_ff.ray_dir_x * s1_dely_ff;
      s2_ns1_in = s1_delx_ff * s1_d_ff.seg_vec_y;
      s2_ns2_in = s1_d_ff.seg_vec_x * s1_dely_ff;
      s2_touch_in = (close_zero(34'(s1_delx_ff), tol) && close_zero(34'(s1_dely_ff), tol))
                 || (close_zero(s1_ex_ff, tol) && close_zero(s1_ey_ff, tol));
      s2_geo_in.ox = s1_d_ff.ray_origin_x;
      s2_geo_in.oy = s1_d_ff.ray_origin_y;
      s2_geo_in.sx = s1_d_ff.seg_start_x;
      s2_geo_in.sy = s1_d_ff.seg_start_y;
      s2_geo_in.vx = s1_d_ff.seg_vec_x;
      s2_geo_in.vy = s1_d_ff.seg_vec_y;
   end

   always_comb begin
      s3_d_in.den   = rsi_pkg::CROSS_W'(s2_dv1_ff) - rsi_pkg::CROSS_W'(s2_dv2_ff);
      s3_d_in.nt    = rsi_pkg::CROSS_W'(s2_nt1_ff) - rsi_pkg::CROSS_W'(s2_nt2_ff);
      s3_d_in.ns    = rsi_pkg::CROSS_W'(s2_ns1_ff) - rsi_pkg::CROSS_W'(s2_ns2_ff);
      s3_d_in.touch = s2_touch_ff;
      s3_d_in.geo   = s2_geo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_d_ff     <= in_data;
         s1_delx_ff  <= s1_delx_in;
         s1_dely_ff  <= s1_dely_in;
         s1_ex_ff    <= s1_ex_in;
         s1_ey_ff    <= s1_ey_in;
         s2_geo_ff   <= s2_geo_in;
         s2_touch_ff <= s2_touch_in;
         s2_dv1_ff   <= s2_dv1_in;
         s2_dv2_ff   <= s2_dv2_in;
         s2_nt1_ff   <= s2_nt1_in;
         s2_nt2_ff   <= s2_nt2_in;
         s2_ns1_ff   <= s2_ns1_in;
         s2_ns2_ff   <= s2_ns2_in;
         s3_d_ff     <= s3_d_in;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_data  = s3_d_ff;

endmodule

// ===== design/rsi_classify.sv =====
// ----------------------------------------------------------------------------
// rsi_classify
// Sign normalization, parallel and range tests, two stages.
// ----------------------------------------------------------------------------
module rsi_classify #(
   parameter int FRAC_BITS = rsi_pkg::FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  rsi_pkg::xs_type           in_data,
   input  logic [rsi_pkg::TOL_W-1:0] tol,
   output logic                      out_valid,
   output rsi_pkg::dv_type           out_data
);

   localparam int CW = rsi_pkg::CROSS_W;

   logic                 a_v_ff;
   logic signed [CW-1:0] a_den_ff, a_nt_ff, a_ns_ff, a_ntabs_ff;
   logic signed [CW-1:0] a_den_in, a_nt_in, a_ns_in, a_ntabs_in;
   logic                 a_touch_ff;
   rsi_pkg::geo_type     a_geo_ff;

   logic                 b_v_ff;
   rsi_pkg::dv_type      b_d_ff, b_d_in;
   logic signed [CW-1:0] thr;
   logic                 par, nz_nt, hit;

   always_comb begin
      a_den_in   = in_data.den[CW-1] ? -in_data.den : in_data.den;
      a_nt_in    = in_data.den[CW-1] ? -in_data.nt  : in_data.nt;
      a_ns_in    = in_data.den[CW-1] ? -in_data.ns  : in_data.ns;
      a_ntabs_in = in_data.nt[CW-1]  ? -in_data.nt  : in_data.nt;
   end

   always_comb begin
      thr   = CW'(tol) << FRAC_BITS;
      par   = a_den_ff <= thr;
      nz_nt = a_ntabs_ff <= thr;
      hit   = !a_ns_ff[CW-1] && !a_nt_ff[CW-1] && !(a_den_ff < a_nt_ff);
      if (par) begin
         b_d_in.side.kind = (nz_nt && a_touch_ff) ? rsi_pkg::HIT_TOUCH : rsi_pkg::HIT_NONE;
      end else begin
         b_d_in.side.kind = hit ? rsi_pkg::HIT_CROSS : rsi_pkg::HIT_NONE;
      end
      b_d_in.side.ax = (b_d_in.side.kind == rsi_pkg::HIT_TOUCH) ? a_geo_ff.ox : a_geo_ff.sx;
      b_d_in.side.ay = (b_d_in.side.kind == rsi_pkg::HIT_TOUCH) ? a_geo_ff.oy : a_geo_ff.sy;
      b_d_in.side.vx = a_geo_ff.vx;
      b_d_in.side.vy = a_geo_ff.vy;
      b_d_in.rem     = a_nt_ff;
      b_d_in.den     = a_den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_valid;
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_den_ff   <= a_den_in;
         a_nt_ff    <= a_nt_in;
         a_ns_ff    <= a_ns_in;
         a_ntabs_ff <= a_ntabs_in;
         a_touch_ff <= in_data.touch;
         a_geo_ff   <= in_data.geo;
         b_d_ff     <= b_d_in;
      end
   end

   assign out_valid = b_v_ff;
   assign out_data  = b_d_ff;

endmodule

// ===== design/rsi_div.sv =====
// ----------------------------------------------------------------------------
// rsi_div
// Restoring divider for t = nt / den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rsi_div #(
   parameter int FRAC_BITS = rsi_pkg::FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  rsi_pkg::dv_type    in_data,
   output logic               out_valid,
   output rsi_pkg::side_type  out_side,
   output logic [FRAC_BITS:0] out_q
);

   localparam int CW = rsi_pkg::CROSS_W;
   localparam int NS = FRAC_BITS + 1;

   logic               v_ff    [NS];
   rsi_pkg::side_type  side_ff [NS];
   logic [CW:0]        rem_ff  [NS];
   logic [CW-1:0]      den_ff  [NS];
   logic [FRAC_BITS:0] q_ff    [NS];

   for (genvar i = 0; i < NS; i++) begin : g_stage
      logic               v_src;
      rsi_pkg::side_type  side_src;
      logic [CW:0]        rem_sh;
      logic [CW-1:0]      den_src;
      logic [FRAC_BITS:0] q_src;
      logic               q_bit;
      logic [CW:0]        rem_in;

      if (i == 0) begin : g_first
         assign v_src    = in_valid;
         assign side_src = in_data.side;
         assign rem_sh   = {1'b0, in_data.rem};
         assign den_src  = in_data.den;
         assign q_src    = '0;
      end else begin : g_next
         assign v_src    = v_ff[i-1];
         assign side_src = side_ff[i-1];
         assign rem_sh   = {rem_ff[i-1][CW-1:0], 1'b0};
         assign den_src  = den_ff[i-1];
         assign q_src    = q_ff[i-1];
      end

      assign q_bit  = rem_sh >= {1'b0, den_src};
      assign rem_in = q_bit ? rem_sh - {1'b0, den_src} : rem_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i] <= side_src;
            rem_ff[i]  <= rem_in;
            den_ff[i]  <= den_src;
            q_ff[i]    <= {q_src[FRAC_BITS-1:0], q_bit};
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_side  = side_ff[NS-1];
   assign out_q     = q_ff[NS-1];

endmodule

// ===== design/rsi_point.sv =====
// ----------------------------------------------------------------------------
// rsi_point
// Scales the edge vector by t, rounds, adds the start point and saturates.
// ----------------------------------------------------------------------------
module rsi_point #(
   parameter int FRAC_BITS = rsi_pkg::FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  rsi_pkg::side_type  in_side,
   input  logic [FRAC_BITS:0] in_q,
   output logic               out_valid,
   output rsi_pkg::rsp_type   out_data
);

   localparam int PW = FRAC_BITS + 34;
   localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
   localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

   function automatic logic signed [31:0] finish(input logic [1:0] kind,
                                                 input logic signed [31:0] a,
                                                 input logic signed [33:0] off);
      logic signed [34:0] sum;
      logic signed [31:0] sat;
      sum = 35'(a) + 35'(off);
      if (sum > SAT_MAX) begin
         sat = 32'sh7FFFFFFF;
      end else if (sum < SAT_MIN) begin
         sat = 32'sh80000000;
      end else begin
         sat = sum[31:0];
      end
      case (kind)
         rsi_pkg::HIT_CROSS: return sat;
         rsi_pkg::HIT_TOUCH: return a;
         default:            return '0;
      endcase
   endfunction

   logic                 p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff;
   rsi_pkg::side_type    p1_side_ff, p2_side_ff, p3_side_ff;
   logic signed [PW-1:0] p1_px_ff, p1_py_ff, p1_px_in, p1_py_in;
   logic [PW-1:0]        p2_mx_ff, p2_my_ff;
   logic                 p2_nx_ff, p2_ny_ff;
   logic [PW-1:0]        rx_sum, ry_sum;
   logic signed [33:0]   p3_ox_ff, p3_oy_ff, p3_ox_in, p3_oy_in;
   rsi_pkg::rsp_type     p4_d_ff, p4_d_in;

   always_comb begin
      p1_px_in = $signed({1'b0, in_q}) * in_side.vx;
      p1_py_in = $signed({1'b0, in_q}) * in_side.vy;
   end

   always_comb begin
      rx_sum   = p2_mx_ff + (PW'(1) << (FRAC_BITS - 1));
      ry_sum   = p2_my_ff + (PW'(1) << (FRAC_BITS - 1));
      p3_ox_in = p2_nx_ff ? -34'(rx_sum >> FRAC_BITS) : 34'(rx_sum >> FRAC_BITS);
      p3_oy_in = p2_ny_ff ? -34'(ry_sum >> FRAC_BITS) : 34'(ry_sum >> FRAC_BITS);
   end

   always_comb begin
      p4_d_in.hit_kind = p3_side_ff.kind;
      p4_d_in.point_x  = finish(p3_side_ff.kind, p3_side_ff.ax, p3_ox_ff);
      p4_d_in.point_y  = finish(p3_side_ff.kind, p3_side_ff.ay, p3_oy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff <= in_valid;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_side_ff <= in_side;
         p1_px_ff   <= p1_px_in;
         p1_py_ff   <= p1_py_in;
         p2_side_ff <= p1_side_ff;
         p2_nx_ff   <= p1_px_ff[PW-1];
         p2_ny_ff   <= p1_py_ff[PW-1];
         p2_mx_ff   <= p1_px_ff[PW-1] ? PW'(-p1_px_ff) : PW'(p1_px_ff);
         p2_my_ff   <= p1_py_ff[PW-1] ? PW'(-p1_py_ff) : PW'(p1_py_ff);
         p3_side_ff <= p2_side_ff;
         p3_ox_ff   <= p3_ox_in;
         p3_oy_ff   <= p3_oy_in;
         p4_d_ff    <= p4_d_in;
      end
   end

   assign out_valid = p4_v_ff;
   assign out_data  = p4_d_ff;

endmodule
